>>> rtl/bba_pkg.sv
package bba_pkg;

  localparam int NUM_BLOCKS    = 4096;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WORD_AW       = $clog2(MAP_WORDS);
  localparam int BIT_AW        = $clog2(MAP_WORD_BITS);
  localparam int IDX_W         = WORD_AW + BIT_AW;

  localparam int COUNT_W = 13;
  localparam int FDB_W   = 16;
  localparam int BN_W    = 17;
  localparam int CFG_AW  = 1;
  localparam int CFG_DW  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);

  localparam logic [CFG_AW-1:0] REG_BLK_TOTAL = 1'b0;
  localparam logic [CFG_AW-1:0] REG_BASE_BLK  = 1'b1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef logic [MAP_WORD_BITS-1:0] word_t;
  typedef logic [WORD_AW-1:0]       waddr_t;

  typedef struct packed {
    logic   rd_en;
    waddr_t rd_addr;
    logic   wr_en;
    waddr_t wr_addr;
    word_t  wr_data;
  } map_req_t;

endpackage

>>> rtl/bba_map.sv
module bba_map (
  input  logic              clk,
  input  logic              rst,
  input  bba_pkg::map_req_t req,
  output bba_pkg::word_t    rd_data
);
  import bba_pkg::*;

  word_t                mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] row_valid;
  word_t                mem_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q <= mem[req.rd_addr];
    end
  end

  // A row that was never written reads as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_q <= row_valid[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_q ? mem_q : '0;

endmodule

>>> rtl/bitmap_block_allocator.sv
// First-fit block allocator over a used-bit map of NUM_BLOCKS blocks.
// Requests arrive on the req channel (action, blk_num) and each one
// gives exactly one response beat on the rsp channel (result_block, ok,
// free_count). A beat moves when valid is high and stall is low.
// Requests are handled one at a time; req_stall is high while a request is
// being worked on.
// An allocate scans the map one word per cycle through a single read port
// of the map memory and stops at the word that holds the lowest free block
// (or at the last managed word when none is free). A free is one
// read-modify-write of one word; a rejected request goes straight to the
// response step.
// The response sits in an output register, so the next request is taken
// while a response still waits; if rsp_stall stays high the following
// response waits in the sequencer and holds the request side.
// Configuration is written through cfg_valid/cfg_ready (always ready). The user
// must change it only while no request is outstanding; the block does not enforce it.
// Reset marks every block free, sets the block count to 4096, the first
// data block to 0 and the free count to 4096; it takes effect at once.
module bitmap_block_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         action,
  input  logic [bba_pkg::BN_W-1:0]     blk_num,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [bba_pkg::BN_W-1:0]     result_block,
  output logic                         ok,
  output logic [bba_pkg::COUNT_W-1:0]  free_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bba_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [bba_pkg::CFG_DW-1:0]   cfg_data
);
  import bba_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SCAN     = 5'b00010,
    ST_FREE_RD  = 5'b00100,
    ST_FREE_MOD = 5'b01000,
    ST_DONE     = 5'b10000
  } state_t;

  state_t               state;
  logic [COUNT_W-1:0]   blk_total;
  logic [FDB_W-1:0]     base_blk;
  logic [COUNT_W-1:0]   free_left;
  logic [IDX_W-1:0]     free_idx;
  waddr_t               issue_word;
  logic                 issue_more;
  logic                 chk_pending;
  waddr_t               chk_word;
  logic [BN_W-1:0]      res_block;
  logic                 res_ok;

  map_req_t             map_req;
  word_t                map_rd_data;

  logic [COUNT_W-1:0]   managed;
  logic [COUNT_W-1:0]   managed_m1;
  waddr_t               last_word;
  logic [BIT_AW-1:0]    last_bit;
  word_t                keep_mask;
  word_t                scan_eff;
  logic                 found;
  logic [BIT_AW-1:0]    zero_bit;
  logic [BN_W:0]        range_lo;
  logic [BN_W:0]        range_hi;
  logic                 in_range;
  logic [BN_W-1:0]      offset;
  logic                 req_take;
  logic                 free_bit_set;

  bba_map u_map (
    .clk     (clk),
    .rst     (rst),
    .req     (map_req),
    .rd_data (map_rd_data)
  );

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;

  always_comb begin
    managed    = (blk_total > COUNT_W'(NUM_BLOCKS)) ? COUNT_W'(NUM_BLOCKS) : blk_total;
    managed_m1 = managed - COUNT_W'(1);
    last_word  = managed_m1[IDX_W-1:BIT_AW];
    last_bit   = managed_m1[BIT_AW-1:0];
    keep_mask  = {MAP_WORD_BITS{1'b1}} >> (BIT_AW'(MAP_WORD_BITS - 1) - last_bit);
    scan_eff   = map_rd_data | ((chk_word == last_word) ? ~keep_mask : '0);
    found      = ~&scan_eff;
    zero_bit   = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!scan_eff[i]) begin
        zero_bit = BIT_AW'(i);
      end
    end
    range_lo     = (BN_W+1)'(base_blk);
    range_hi     = (BN_W+1)'(base_blk) + (BN_W+1)'(managed);
    in_range     = ((BN_W+1)'(blk_num) >= range_lo) &&
                   ((BN_W+1)'(blk_num) < range_hi);
    offset       = blk_num - BN_W'(base_blk);
    free_bit_set = map_rd_data[free_idx[BIT_AW-1:0]];
  end

  always_comb begin
    map_req = '0;
    case (state)
      ST_SCAN: begin
        map_req.rd_en   = issue_more;
        map_req.rd_addr = issue_word;
        map_req.wr_en   = chk_pending && found;
        map_req.wr_addr = chk_word;
        map_req.wr_data = map_rd_data | (word_t'(1) << zero_bit);
      end
      ST_FREE_RD: begin
        map_req.rd_en   = 1'b1;
        map_req.rd_addr = free_idx[IDX_W-1:BIT_AW];
      end
      ST_FREE_MOD: begin
        map_req.wr_en   = free_bit_set;
        map_req.wr_addr = free_idx[IDX_W-1:BIT_AW];
        map_req.wr_data = map_rd_data & ~(word_t'(1) << free_idx[BIT_AW-1:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_total <= COUNT_RESET;
      base_blk  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLK_TOTAL: blk_total <= cfg_data[COUNT_W-1:0];
        REG_BASE_BLK:  base_blk  <= cfg_data[FDB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      free_left   <= COUNT_RESET;
      issue_more  <= 1'b0;
      chk_pending <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_take) begin
            res_block <= '0;
            res_ok    <= 1'b0;
            if (action == ACT_ALLOC) begin
              issue_word  <= '0;
              issue_more  <= 1'b1;
              chk_pending <= 1'b0;
              state       <= (managed == '0) ? ST_DONE : ST_SCAN;
            end else begin
              free_idx <= offset[IDX_W-1:0];
              state    <= in_range ? ST_FREE_RD : ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          chk_word <= issue_word;
          if (chk_pending && (found || chk_word == last_word)) begin
            if (found) begin
              res_block <= BN_W'({chk_word, zero_bit}) + BN_W'(base_blk);
              res_ok    <= 1'b1;
              if (free_left != '0) begin
                free_left <= free_left - COUNT_W'(1);
              end
            end
            issue_more  <= 1'b0;
            chk_pending <= 1'b0;
            state       <= ST_DONE;
          end else begin
            chk_pending <= issue_more;
            if (issue_more) begin
              if (issue_word == last_word) begin
                issue_more <= 1'b0;
              end else begin
                issue_word <= issue_word + WORD_AW'(1);
              end
            end
          end
        end
        ST_FREE_RD: begin
          state <= ST_FREE_MOD;
        end
        ST_FREE_MOD: begin
          res_ok <= 1'b1;
          if (free_bit_set && free_left != COUNT_MAX) begin
            free_left <= free_left + COUNT_W'(1);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (state == ST_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid    <= 1'b1;
        result_block <= res_block;
        ok           <= res_ok;
        free_count   <= free_left;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !ok |-> result_block == '0)
    else $error("failed request returned a nonzero block");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    map_req.wr_en |-> (state == ST_SCAN || state == ST_FREE_MOD))
    else $error("map written outside scan or free update");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    req_take |=> state != ST_IDLE)
    else $error("sequencer stayed idle after taking a request");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(free_left) |->
      ($past(state) == ST_SCAN || $past(state) == ST_FREE_MOD))
    else $error("free count changed outside an update step");

  a_scan_pending: assert property (@(posedge clk) disable iff (rst)
    chk_pending |-> state == ST_SCAN || state == ST_DONE)
    else $error("scan check pending outside the scan");

endmodule
